/* rtl/sbleq_pkg.sv */
// sbleq_pkg: shared types and constants for the subtract-and-branch processor
// no dependencies; imported by subtract_branch_if_leq_cpu and tb_top
package sbleq_pkg;

	typedef logic [63:0] word_t;
	typedef logic [1:0]  opcode_t;
	typedef logic [1:0]  status_t;
	typedef logic [7:0]  byte_t;

	// transaction opcodes
	localparam opcode_t OP_WRITE = 2'd0;
	localparam opcode_t OP_SETIP = 2'd1;
	localparam opcode_t OP_EXEC  = 2'd2;
	localparam opcode_t OP_READ  = 2'd3;

	// run status codes
	localparam status_t ST_RUN  = 2'd0;
	localparam status_t ST_EXIT = 2'd1;
	localparam status_t ST_MERR = 2'd2;

	// special addresses at the top of the address space
	localparam word_t IO_BASE    = 64'hFFFF_FFFF_FFFF_FFE0;
	localparam word_t ADDR_EXIT  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam word_t ADDR_PRINT = 64'hFFFF_FFFF_FFFF_FFFE;
	localparam word_t ADDR_STDIN = 64'hFFFF_FFFF_FFFF_FFFD;
	localparam word_t ADDR_FREQ  = 64'hFFFF_FFFF_FFFF_FFFC;
	localparam word_t ADDR_TIME  = 64'hFFFF_FFFF_FFFF_FFFB;
	localparam word_t ADDR_SLEEP = 64'hFFFF_FFFF_FFFF_FFFA;
	localparam word_t FREQ_VALUE = 64'h0000_0001_0000_0000;

	// sequencer states, one-hot
	typedef enum logic [10:0] {
		S_CLEAR   = 11'b000_0000_0001,
		S_IDLE    = 11'b000_0000_0010,
		S_WRITE   = 11'b000_0000_0100,
		S_RD_REQ  = 11'b000_0000_1000,
		S_RD_DATA = 11'b000_0001_0000,
		S_FA      = 11'b000_0010_0000,
		S_FB      = 11'b000_0100_0000,
		S_FC      = 11'b000_1000_0000,
		S_RMB     = 11'b001_0000_0000,
		S_RMA     = 11'b010_0000_0000,
		S_EXEC    = 11'b100_0000_0000
	} state_t;

endpackage

/* rtl/subtract_branch_if_leq_cpu.sv */
// Set ip, and execute while halted, finish straight from idle; a write passes S_WRITE,
// a read S_RD_REQ and S_RD_DATA, and an executed instruction three fetches, two operand
// reads and a write back. One transaction at a time; busy is low again in the done cycle.
// After reset the memory is cleared one word per cycle, busy staying high until the end.
// done is a one-cycle strobe; results hold until the next start; the receiver cannot stall.
// subtract_branch_if_leq_cpu: top level, sequencer and word memory; depends on sbleq_pkg
module subtract_branch_if_leq_cpu #(
	parameter int MEM_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sbleq_pkg::opcode_t opcode,
	input  sbleq_pkg::word_t   address,
	input  sbleq_pkg::word_t   data,
	input  sbleq_pkg::byte_t   in_byte,
	input  sbleq_pkg::word_t   time_now,
	output logic               done,
	output sbleq_pkg::status_t status,
	output sbleq_pkg::word_t   ip_now,
	output sbleq_pkg::word_t   read_data,
	output logic               out_valid,
	output sbleq_pkg::byte_t   out_byte,
	output logic               sleep_valid,
	output sbleq_pkg::word_t   sleep_amount,
	output logic               byte_taken
);
	import sbleq_pkg::*;

	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam word_t DEPTH_W = 64'(MEM_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

	state_t state_q;
	logic [AW-1:0] clr_q;
	word_t addr_q, data_q, time_q;
	byte_t inb_q;
	word_t ip_q;
	status_t status_q;
	word_t a_q, b_q, c_q, mb_q;
	logic rd_ok_q;
	logic done_q;
	word_t read_data_q, sleep_amount_q;
	logic out_valid_q, sleep_valid_q, byte_taken_q;
	byte_t out_byte_q;

	word_t mem [MEM_DEPTH];
	word_t rdata_q;

	word_t rd_addr, wr_addr64, wr_data;
	logic rd_ok, wr_en;
	logic [AW-1:0] rd_idx, wr_idx;
	word_t rval, diff;
	logic a_in;

	// read data of the previous read, zero beyond memory
	assign rval = rd_ok_q ? rdata_q : '0;
	assign a_in = (a_q < DEPTH_W);
	assign diff = rval - mb_q;

	// read address select
	always_comb begin
		unique case (state_q)
			S_RD_REQ: rd_addr = addr_q;
			S_FA:     rd_addr = ip_q;
			S_FB:     rd_addr = ip_q + 64'd1;
			S_FC:     rd_addr = ip_q + 64'd2;
			S_RMB:    rd_addr = b_q;
			S_RMA:    rd_addr = a_q;
			default:  rd_addr = ip_q;
		endcase
		rd_ok  = (rd_addr < DEPTH_W);
		rd_idx = rd_ok ? rd_addr[AW-1:0] : '0;
	end

	// write port select
	always_comb begin
		wr_en     = 1'b0;
		wr_addr64 = '0;
		wr_data   = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en     = 1'b1;
				wr_addr64 = 64'(clr_q);
			end
			S_WRITE: begin
				wr_en     = (addr_q < DEPTH_W);
				wr_addr64 = addr_q;
				wr_data   = data_q;
			end
			S_EXEC: begin
				wr_en     = a_in;
				wr_addr64 = a_q;
				wr_data   = diff;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		wr_idx = wr_en ? wr_addr64[AW-1:0] : '0;
	end

	// word memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_data;
		rdata_q <= mem[rd_idx];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			ip_q     <= '0;
			status_q <= ST_RUN;
			done_q   <= 1'b0;
			rd_ok_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			rd_ok_q <= rd_ok;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						addr_q         <= address;
						data_q         <= data;
						inb_q          <= in_byte;
						time_q         <= time_now;
						read_data_q    <= '0;
						out_valid_q    <= 1'b0;
						out_byte_q     <= '0;
						sleep_valid_q  <= 1'b0;
						sleep_amount_q <= '0;
						byte_taken_q   <= 1'b0;
						unique case (opcode)
							OP_WRITE: state_q <= S_WRITE;
							OP_SETIP: begin
								ip_q   <= data;
								done_q <= 1'b1;
							end
							OP_READ:  state_q <= S_RD_REQ;
							OP_EXEC: begin
								if (status_q == ST_RUN)
									state_q <= S_FA;
								else
									done_q <= 1'b1;
							end
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_WRITE: begin
					if (addr_q >= DEPTH_W && data_q != '0)
						status_q <= ST_MERR;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RD_REQ: state_q <= S_RD_DATA;
				S_RD_DATA: begin
					read_data_q <= rval;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FA: state_q <= S_FB;
				S_FB: begin
					a_q     <= rval;
					state_q <= S_FC;
				end
				S_FC: begin
					b_q     <= rval;
					state_q <= S_RMB;
				end
				S_RMB: begin
					c_q     <= rval;
					state_q <= S_RMA;
				end
				// operand b value, memory or host port
				S_RMA: begin
					if (b_q < DEPTH_W)
						mb_q <= rval;
					else if (b_q == ADDR_STDIN)
						mb_q <= 64'(inb_q);
					else if (b_q == ADDR_FREQ)
						mb_q <= FREQ_VALUE;
					else if (b_q == ADDR_TIME)
						mb_q <= time_q;
					else
						mb_q <= '0;
					byte_taken_q <= (b_q == ADDR_STDIN);
					state_q      <= S_EXEC;
				end
				// subtract, branch and host events
				S_EXEC: begin
					if (a_in) begin
						ip_q <= (rval <= mb_q) ? c_q : ip_q + 64'd3;
					end else begin
						ip_q <= c_q;
						if (a_q < IO_BASE) begin
							if (mb_q != '0)
								status_q <= ST_MERR;
						end else if (a_q == ADDR_EXIT) begin
							status_q <= ST_EXIT;
						end else if (a_q == ADDR_PRINT) begin
							out_valid_q <= 1'b1;
							out_byte_q  <= mb_q[7:0];
						end else if (a_q == ADDR_SLEEP) begin
							sleep_valid_q  <= 1'b1;
							sleep_amount_q <= mb_q;
						end
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result ports
	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign ip_now       = ip_q;
	assign read_data    = read_data_q;
	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign sleep_valid  = sleep_valid_q;
	assign sleep_amount = sleep_amount_q;
	assign byte_taken   = byte_taken_q;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for subtract_branch_if_leq_cpu
// runs directed and random transactions against a local model of memory, ip and status
// depends on sbleq_pkg and subtract_branch_if_leq_cpu
module tb_top;
	import sbleq_pkg::*;

	localparam int    MEM_WORDS   = 4096;
	localparam word_t MEM_LIMIT   = 64'd4096;
	localparam int    STALL_LIMIT = 20000;
	localparam int    REGION_TOP  = 47;

	typedef struct packed {
		opcode_t op;
		word_t   addr;
		word_t   data;
		byte_t   inb;
		word_t   tnow;
	} cmd_t;

	typedef struct packed {
		status_t st;
		word_t   ip;
		word_t   rd;
		logic    ov;
		byte_t   ob;
		logic    sv;
		word_t   sa;
		logic    bt;
	} outcome_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	opcode_t opcode = OP_READ;
	word_t   address = '0;
	word_t   data = '0;
	byte_t   in_byte = '0;
	word_t   time_now = '0;
	logic    busy;
	logic    done;
	status_t status;
	word_t   ip_now;
	word_t   read_data;
	logic    out_valid;
	byte_t   out_byte;
	logic    sleep_valid;
	word_t   sleep_amount;
	logic    byte_taken;

	// model of the processor state
	word_t   model_mem [MEM_WORDS];
	word_t   model_ip;
	status_t model_status;

	outcome_t pending [$];
	int       sender_idle_pct = 33;
	int       sent_count = 0;
	int       error_count = 0;
	int       stall_cycles = 0;

	subtract_branch_if_leq_cpu #(
		.MEM_DEPTH(MEM_WORDS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.address(address),
		.data(data),
		.in_byte(in_byte),
		.time_now(time_now),
		.done(done),
		.status(status),
		.ip_now(ip_now),
		.read_data(read_data),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.sleep_valid(sleep_valid),
		.sleep_amount(sleep_amount),
		.byte_taken(byte_taken)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model memory access
	function automatic word_t model_load(word_t addr);
		return (addr < MEM_LIMIT) ? model_mem[addr] : '0;
	endfunction

	function automatic void model_store(word_t addr, word_t value);
		if (addr < MEM_LIMIT) begin
			model_mem[addr] = value;
		end else if (value != '0) begin
			model_status = ST_MERR;
		end
	endfunction

	// value of operand b, memory or host input
	function automatic word_t operand_value(word_t b, byte_t inb, word_t tnow);
		if (b < MEM_LIMIT)
			return model_mem[b];
		else if (b == ADDR_STDIN)
			return {56'd0, inb};
		else if (b == ADDR_FREQ)
			return FREQ_VALUE;
		else if (b == ADDR_TIME)
			return tnow;
		return '0;
	endfunction

	// advance the model by one transaction and return the expected result
	function automatic outcome_t predict_outcome(cmd_t cmd);
		outcome_t r;
		word_t    ip;
		word_t    a;
		word_t    b;
		word_t    c;
		word_t    ma;
		word_t    mb;
		r = '0;
		case (cmd.op)
			OP_WRITE: begin
				model_store(cmd.addr, cmd.data);
			end
			OP_SETIP: begin
				model_ip = cmd.data;
			end
			OP_READ: begin
				r.rd = model_load(cmd.addr);
			end
			default: begin
				if (model_status == ST_RUN) begin
					ip = model_ip;
					a = model_load(ip);
					b = model_load(ip + 64'd1);
					c = model_load(ip + 64'd2);
					mb = operand_value(b, cmd.inb, cmd.tnow);
					r.bt = (b == ADDR_STDIN);
					if (a < MEM_LIMIT) begin
						ma = model_mem[a];
						model_ip = (ma <= mb) ? c : ip + 64'd3;
						model_mem[a] = ma - mb;
					end else begin
						model_ip = c;
						if (a < IO_BASE) begin
							model_store(a, word_t'(0) - mb);
						end else if (a == ADDR_EXIT) begin
							model_status = ST_EXIT;
						end else if (a == ADDR_PRINT) begin
							r.ov = 1'b1;
							r.ob = mb[7:0];
						end else if (a == ADDR_SLEEP) begin
							r.sv = 1'b1;
							r.sa = mb;
						end
					end
				end
			end
		endcase
		r.st = model_status;
		r.ip = model_ip;
		return r;
	endfunction

	// true when executing now would stop the processor
	function automatic bit exec_would_halt(byte_t inb, word_t tnow);
		word_t a;
		word_t b;
		if (model_status != ST_RUN)
			return 1'b0;
		a = model_load(model_ip);
		b = model_load(model_ip + 64'd1);
		if (a == ADDR_EXIT)
			return 1'b1;
		return a >= MEM_LIMIT && a < IO_BASE && operand_value(b, inb, tnow) != '0;
	endfunction

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic word_t rand_value();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return word_t'($urandom_range(300));
			3: return word_t'(1) << $urandom_range(63);
			default: return rand_word();
		endcase
	endfunction

	// operand address: mostly the program region, plus special and far addresses
	function automatic word_t rand_operand();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return word_t'($urandom_range(REGION_TOP));
		else if (pick < 72)
			return word_t'(0) - word_t'($urandom_range(1, 32));
		else if (pick < 80)
			return MEM_LIMIT + word_t'($urandom_range(100));
		else if (pick < 88)
			return word_t'($urandom_range(MEM_WORDS - 1));
		return rand_word();
	endfunction

	// one transaction: optional idle gap, then hold start until accepted
	task automatic send_transaction(input opcode_t op, input word_t addr, input word_t value,
			input byte_t inb, input word_t tnow);
		int   gap;
		cmd_t cmd;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.op = op;
		cmd.addr = addr;
		cmd.data = value;
		cmd.inb = inb;
		cmd.tnow = tnow;
		start <= 1'b1;
		opcode <= op;
		address <= addr;
		data <= value;
		in_byte <= inb;
		time_now <= tnow;
		do @(posedge clk); while (busy !== 1'b0);
		pending.push_back(predict_outcome(cmd));
		sent_count++;
	endtask

	task automatic send_op(input opcode_t op, input word_t addr, input word_t value);
		send_transaction(op, addr, value, byte_t'($urandom_range(255)), rand_value());
	endtask

	task automatic write_instruction(input word_t at, input word_t a, input word_t b,
			input word_t c);
		send_op(OP_WRITE, at, a);
		send_op(OP_WRITE, at + 64'd1, b);
		send_op(OP_WRITE, at + 64'd2, c);
	endtask

	// execute unless it would halt; then patch operand a with a safe address
	task automatic run_step();
		byte_t inb;
		word_t tnow;
		inb = byte_t'($urandom_range(255));
		tnow = rand_value();
		if (exec_would_halt(inb, tnow))
			send_op(OP_WRITE, model_ip, word_t'($urandom_range(REGION_TOP)));
		else
			send_transaction(OP_EXEC, '0, rand_word(), inb, tnow);
	endtask

	// memory is cleared by reset, and a read beyond its end returns zero
	task automatic test_reset_values();
		send_op(OP_READ, '0, rand_word());
		send_op(OP_READ, '1, rand_word());
	endtask

	// word write at both ends and past the end, word read at the top end and past the end
	task automatic test_write_read();
		send_op(OP_WRITE, '0, '1);
		send_op(OP_WRITE, MEM_LIMIT - 64'd1, 64'h0123_4567_89AB_CDEF);
		send_op(OP_WRITE, MEM_LIMIT, '0);
		send_op(OP_READ, MEM_LIMIT - 64'd1, '0);
		send_op(OP_READ, MEM_LIMIT, '0);
	endtask

	// chained program touching print, sleep, stdin, time, freq and io addresses
	task automatic test_special_addresses();
		write_instruction(64'd16, ADDR_PRINT, ADDR_STDIN, 64'd19);
		write_instruction(64'd19, ADDR_SLEEP, ADDR_TIME, 64'd22);
		write_instruction(64'd22, 64'd0, ADDR_FREQ, 64'd0);
		write_instruction(64'd25, word_t'(0) - 64'd10, word_t'(0) - 64'd7, 64'd28);
		write_instruction(64'd28, MEM_LIMIT, MEM_LIMIT + 64'd4, 64'd31);
		send_op(OP_SETIP, '0, 64'd16);
		repeat (6) send_op(OP_EXEC, '0, '0);
	endtask

	// fetch addresses wrap around the top of the address space
	task automatic test_ip_wrap();
		send_op(OP_SETIP, '0, '1);
		send_op(OP_EXEC, '0, '0);
		send_op(OP_SETIP, '0, word_t'(0) - 64'd2);
		send_op(OP_EXEC, '0, '0);
	endtask

	// short program written into the region and stepped through
	task automatic program_burst();
		word_t base;
		int    words;
		int    steps;
		base = word_t'($urandom_range(REGION_TOP - 8));
		words = $urandom_range(3, 9);
		for (int i = 0; i < words; i++)
			send_op(OP_WRITE, base + word_t'(i),
				($urandom_range(99) < 70) ? rand_operand() : rand_value());
		if ($urandom_range(99) < 80)
			send_op(OP_SETIP, '0, base);
		steps = $urandom_range(2, 16);
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(99) < 10)
				send_op(OP_READ, word_t'($urandom_range(REGION_TOP)), rand_word());
			run_step();
		end
	endtask

	// single unrelated transaction
	task automatic noise_item();
		word_t addr;
		case (opcode_t'($urandom_range(3)))
			OP_WRITE: begin
				case ($urandom_range(4))
					0, 1: send_op(OP_WRITE, word_t'($urandom_range(REGION_TOP)), rand_value());
					2: send_op(OP_WRITE, word_t'($urandom_range(MEM_WORDS - 1)), rand_word());
					default: begin
						addr = rand_word();
						if (addr < MEM_LIMIT)
							addr = addr + MEM_LIMIT;
						send_op(OP_WRITE, addr, '0);
					end
				endcase
			end
			OP_SETIP: begin
				case ($urandom_range(2))
					0: send_op(OP_SETIP, rand_word(), rand_operand());
					1: send_op(OP_SETIP, rand_word(), rand_word());
					default: send_op(OP_SETIP, rand_word(),
						word_t'(0) - word_t'($urandom_range(1, 4)));
				endcase
			end
			OP_READ: begin
				if ($urandom_range(1))
					send_op(OP_READ, rand_word(), rand_word());
				else
					send_op(OP_READ, word_t'($urandom_range(REGION_TOP)), rand_word());
			end
			default: begin
				run_step();
			end
		endcase
	endtask

	task automatic test_random_traffic(input int idle_pct, input int count);
		int target;
		sender_idle_pct = idle_pct;
		target = sent_count + count;
		while (sent_count < target) begin
			if ($urandom_range(99) < 65)
				program_burst();
			else
				noise_item();
		end
	endtask

	// stop by exit or by a bad store, then check what still works while halted
	task automatic test_halt();
		if ($urandom_range(1))
			write_instruction(64'd40, ADDR_EXIT, 64'd5, 64'd7);
		else
			write_instruction(64'd40, MEM_LIMIT + 64'd9, ADDR_FREQ, 64'd7);
		send_op(OP_SETIP, '0, 64'd40);
		send_op(OP_EXEC, '0, '0);
		send_op(OP_EXEC, '0, '0);
		send_op(OP_SETIP, '0, 64'd3);
		send_op(OP_WRITE, 64'd5, 64'hDEAD_BEEF_0000_0001);
		send_op(OP_WRITE, '1, 64'd1);
		send_op(OP_EXEC, '0, '0);
		send_op(OP_READ, 64'd5, '0);
	endtask

	function automatic void check_field(string name, word_t expected, word_t actual);
		if (actual !== expected) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
			error_count++;
		end
	endfunction

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		outcome_t exp_out;
		if (arst_n && done === 1'b1) begin
			if (pending.size() == 0) begin
				$error("result with no transaction outstanding");
				error_count++;
			end else begin
				exp_out = pending.pop_front();
				check_field("status", exp_out.st, status);
				check_field("ip_now", exp_out.ip, ip_now);
				check_field("read_data", exp_out.rd, read_data);
				check_field("out_valid", exp_out.ov, out_valid);
				check_field("out_byte", exp_out.ob, out_byte);
				check_field("sleep_valid", exp_out.sv, sleep_valid);
				check_field("sleep_amount", exp_out.sa, sleep_amount);
				check_field("byte_taken", exp_out.bt, byte_taken);
			end
		end
	end

	// watchdog on cycles with no accepted transaction and no result
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MEM_WORDS; i++)
			model_mem[i] = '0;
		model_ip = '0;
		model_status = ST_RUN;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_write_read();
		test_special_addresses();
		test_ip_wrap();
		test_random_traffic(33, 417);
		test_random_traffic(83, 417);
		test_random_traffic(0, 416);
		test_halt();
		start <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/sbleq_pkg.sv
rtl/subtract_branch_if_leq_cpu.sv
tb/tb_top.sv
